### rtl/core/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg: shared definitions for the binary min-heap queue
// Default sizes, operation kinds, result status codes and sequencer states.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  // Default sizes of the heap and of one entry.
  localparam int unsigned HEAP_DEPTH_DEF   = 1024;
  localparam int unsigned KEY_BITS_DEF     = 32;
  localparam int unsigned PAYLOAD_BITS_DEF = 16;

  // Operation kind carried on the input tuser.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Result status carried on the output tuser.
  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_PLACE,
    ST_POP_RD,
    ST_DOWN,
    ST_DONE
  } state_e;

endpackage

### rtl/core/bmhq_store.sv
// ----------------------------------------------------------------------------
// bmhq_store: heap entry storage
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bmhq_store #(
  parameter int unsigned DEPTH  = bmhq_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH),
  parameter int unsigned DATA_W = bmhq_pkg::KEY_BITS_DEF + bmhq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_a_i,
  input  logic [ADDR_W-1:0] raddr_b_i,
  output logic [DATA_W-1:0] rdata_a_o,
  output logic [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Two registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### rtl/core/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue: binary min-heap priority queue
// Push and pop of key/payload entries with status and occupancy per beat.
// ----------------------------------------------------------------------------
// Each input beat is one operation and gives exactly one output beat. A push
// places the entry at the end of the heap and moves it up while the parent
// key is strictly greater; a pop returns the root and sifts the last entry
// down from the root, the left child winning ties. The block handles one
// operation at a time. A push moves the entry up a level in each pass through
// ST_UP until it settles, and enters ST_PLACE when it reaches the root; a pop
// reads the root and the last entry in ST_POP_RD and then moves the entry
// down a level in each pass through ST_DOWN. A rejected push, a pop on an
// empty heap and a push into an empty heap go straight to ST_DONE, and a pop
// that empties the heap goes from ST_POP_RD to ST_DONE. Each tree level needs
// one registered read of the parent or of both children before the compare.
// A finished result sits in the output register while the next beat is taken;
// a result still waiting there holds the block in ST_DONE.
module binary_min_heap_queue #(
  parameter int unsigned HEAP_DEPTH   = bmhq_pkg::HEAP_DEPTH_DEF,
  parameter int unsigned KEY_BITS     = bmhq_pkg::KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = bmhq_pkg::PAYLOAD_BITS_DEF,
  localparam int unsigned CNT_W  = $clog2(HEAP_DEPTH + 1),
  localparam int unsigned IN_W   = PAYLOAD_BITS + KEY_BITS,
  localparam int unsigned IN_TW  = ((IN_W + 7) / 8) * 8,
  localparam int unsigned OUT_W  = PAYLOAD_BITS + KEY_BITS + CNT_W,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input tdata fields from bit 0: entry_payload, entry_key.
  input  logic [IN_TW-1:0]  s_axis_tdata,
  // Input tuser fields from bit 0: kind.
  input  logic [0:0]        s_axis_tuser,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // Output tdata fields from bit 0: popped_payload, popped_key, occupancy.
  output logic [OUT_TW-1:0] m_axis_tdata,
  // Output tuser fields from bit 0: status.
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready
);

  localparam int unsigned IDX_W = $clog2(HEAP_DEPTH);
  localparam int unsigned ENT_W = KEY_BITS + PAYLOAD_BITS;
  localparam int unsigned CHW   = IDX_W + 2;

  // Sequencer and datapath registers.
  bmhq_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic [ENT_W-1:0]  mov_q, mov_d;
  bmhq_pkg::status_e res_status_q, res_status_d;
  logic [KEY_BITS-1:0]     res_key_q, res_key_d;
  logic [PAYLOAD_BITS-1:0] res_pay_q, res_pay_d;

  logic              out_valid_q, out_valid_d;
  logic [OUT_TW-1:0] out_data_q, out_data_d;
  logic [1:0]        out_user_q, out_user_d;

  // Storage ports.
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [ENT_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

  // Input beat fields.
  logic                    s_fire;
  logic                    in_kind;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic [KEY_BITS-1:0]     in_key;
  logic [ENT_W-1:0]        in_ent;

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign in_kind = s_axis_tuser[0];
  assign in_pay  = s_axis_tdata[PAYLOAD_BITS-1:0];
  assign in_key  = s_axis_tdata[IN_W-1:PAYLOAD_BITS];
  assign in_ent  = {in_key, in_pay};

  // Heap shape: full, empty, index of the last entry.
  logic             is_full, is_empty;
  logic [CNT_W-1:0] last_cnt;
  logic [IDX_W-1:0] last_idx;

  assign is_full  = (count_q == CNT_W'(HEAP_DEPTH));
  assign is_empty = (count_q == '0);
  assign last_cnt = count_q - CNT_W'(1);
  assign last_idx = last_cnt[IDX_W-1:0];

  // Sift-up compare against the parent key.
  logic [IDX_W-1:0]    par_idx, gpar_idx, new_par_idx;
  logic [KEY_BITS-1:0] mov_key, a_key, b_key;
  logic                up_swap;

  assign par_idx     = (pos_q - IDX_W'(1)) >> 1;
  assign gpar_idx    = (par_idx - IDX_W'(1)) >> 1;
  assign new_par_idx = last_idx >> 1;
  assign mov_key     = mov_q[ENT_W-1:PAYLOAD_BITS];
  assign a_key       = mem_rdata_a[ENT_W-1:PAYLOAD_BITS];
  assign b_key       = mem_rdata_b[ENT_W-1:PAYLOAD_BITS];
  assign up_swap     = (a_key > mov_key);

  // Sift-down selection among the moving entry and both children.
  logic [CHW-1:0]      lc_w, rc_w;
  logic                lc_ok, rc_ok, l_wins, r_wins, down_move;
  logic [KEY_BITS-1:0] best_key;
  logic [IDX_W-1:0]    best_idx;
  logic [ENT_W-1:0]    best_ent;
  logic [IDX_W:0]      glc_w, grc_w;

  assign lc_w      = {1'b0, pos_q, 1'b1};
  assign rc_w      = lc_w + CHW'(1);
  assign lc_ok     = (lc_w < CHW'(count_q));
  assign rc_ok     = (rc_w < CHW'(count_q));
  assign l_wins    = lc_ok && (a_key < mov_key);
  assign best_key  = l_wins ? a_key : mov_key;
  assign r_wins    = rc_ok && (b_key < best_key);
  assign down_move = l_wins || r_wins;
  assign best_idx  = r_wins ? rc_w[IDX_W-1:0] : lc_w[IDX_W-1:0];
  assign best_ent  = r_wins ? mem_rdata_b : mem_rdata_a;
  assign glc_w     = {best_idx, 1'b1};
  assign grc_w     = glc_w + (IDX_W+1)'(1);

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      bmhq_pkg::ST_IDLE: begin
        if (s_fire) begin
          if (in_kind == bmhq_pkg::KIND_PUSH) begin
            state_d = (is_full || is_empty) ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_UP;
          end else begin
            state_d = is_empty ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_POP_RD;
          end
        end
      end
      bmhq_pkg::ST_UP: begin
        if (up_swap) begin
          state_d = (par_idx == '0) ? bmhq_pkg::ST_PLACE : bmhq_pkg::ST_UP;
        end else begin
          state_d = bmhq_pkg::ST_DONE;
        end
      end
      bmhq_pkg::ST_PLACE:  state_d = bmhq_pkg::ST_DONE;
      bmhq_pkg::ST_POP_RD: state_d = is_empty ? bmhq_pkg::ST_DONE : bmhq_pkg::ST_DOWN;
      bmhq_pkg::ST_DOWN:   state_d = down_move ? bmhq_pkg::ST_DOWN : bmhq_pkg::ST_DONE;
      bmhq_pkg::ST_DONE:   state_d = out_free ? bmhq_pkg::ST_IDLE : bmhq_pkg::ST_DONE;
      default:             state_d = bmhq_pkg::ST_IDLE;
    endcase
  end

  // Datapath, storage control and output register loads.
  always_comb begin
    count_d      = count_q;
    pos_d        = pos_q;
    mov_d        = mov_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_pay_d    = res_pay_q;
    mem_we       = 1'b0;
    mem_waddr    = pos_q;
    mem_wdata    = mov_q;
    mem_raddr_a  = par_idx;
    mem_raddr_b  = last_idx;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    out_user_d   = out_user_q;
    case (state_q)
      bmhq_pkg::ST_IDLE: begin
        if (s_fire) begin
          res_key_d = '0;
          res_pay_d = '0;
          if (in_kind == bmhq_pkg::KIND_PUSH) begin
            if (is_full) begin
              res_status_d = bmhq_pkg::STATUS_FULL;
            end else begin
              res_status_d = bmhq_pkg::STATUS_OK;
              mov_d        = in_ent;
              pos_d        = count_q[IDX_W-1:0];
              count_d      = count_q + CNT_W'(1);
              mem_raddr_a  = new_par_idx;
              // First entry goes straight to the root.
              if (is_empty) begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = in_ent;
              end
            end
          end else begin
            if (is_empty) begin
              res_status_d = bmhq_pkg::STATUS_EMPTY;
            end else begin
              res_status_d = bmhq_pkg::STATUS_OK;
              mem_raddr_a  = '0;
              mem_raddr_b  = last_idx;
              count_d      = last_cnt;
              pos_d        = '0;
            end
          end
        end
      end
      bmhq_pkg::ST_UP: begin
        // Parent moves down into the hole, or the entry settles here.
        mem_we = 1'b1;
        if (up_swap) begin
          mem_wdata   = mem_rdata_a;
          pos_d       = par_idx;
          mem_raddr_a = gpar_idx;
        end
      end
      bmhq_pkg::ST_PLACE: begin
        mem_we = 1'b1;
      end
      bmhq_pkg::ST_POP_RD: begin
        // Root is the result; the last entry starts sifting from the root.
        res_key_d   = a_key;
        res_pay_d   = mem_rdata_a[PAYLOAD_BITS-1:0];
        mov_d       = mem_rdata_b;
        mem_raddr_a = lc_w[IDX_W-1:0];
        mem_raddr_b = rc_w[IDX_W-1:0];
      end
      bmhq_pkg::ST_DOWN: begin
        mem_we = 1'b1;
        if (down_move) begin
          mem_wdata   = best_ent;
          pos_d       = best_idx;
          mem_raddr_a = glc_w[IDX_W-1:0];
          mem_raddr_b = grc_w[IDX_W-1:0];
        end
      end
      bmhq_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_TW'({count_q, res_key_q, res_pay_q});
          out_user_d  = res_status_q;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmhq_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q        <= pos_d;
    mov_q        <= mov_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_pay_q    <= res_pay_d;
    out_data_q   <= out_data_d;
    out_user_q   <= out_user_d;
  end

  bmhq_store #(
    .DEPTH  (HEAP_DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (ENT_W)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

  assign s_axis_tready = (state_q == bmhq_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

`ifndef ASSERT_OFF
  // The entry count never goes past the heap depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(HEAP_DEPTH))
    else $error("entry count exceeds heap depth");

  // An accepted push into a heap with room adds exactly one entry.
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_kind == bmhq_pkg::KIND_PUSH && !is_full)
      |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("push did not add one entry");

  // An accepted pop from a non-empty heap removes exactly one entry.
  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && in_kind == bmhq_pkg::KIND_POP && !is_empty)
      |=> count_q == $past(count_q) - CNT_W'(1))
    else $error("pop did not remove one entry");

  // Storage is never written while waiting for an operation.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bmhq_pkg::ST_IDLE && !s_fire) |-> !mem_we)
    else $error("storage written while idle");
`endif

endmodule

### tb/binary_min_heap_queue_test.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue_test: self-checking bench for the min-heap queue
// Drives push and pop beats with random gaps and back-pressure, predicts
// every result beat from a local heap model and compares status, popped
// entry and occupancy field by field.
// ----------------------------------------------------------------------------
module binary_min_heap_queue_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH       = bmhq_pkg::HEAP_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned HOLD_CYCLES = 300;

  // One result beat as the block should present it.
  typedef struct packed {
    bmhq_pkg::status_e status;
    logic [15:0]       payload;
    logic [31:0]       key;
    logic [10:0]       occupancy;
  } heap_result_t;

  // Keeps a private copy of the heap and the results still owed by the block.
  class min_heap_predictor;
    logic [31:0]  key_mem [DEPTH];
    logic [15:0]  pay_mem [DEPTH];
    int unsigned  held;
    heap_result_t awaited_results [$];
    int unsigned  mismatches;
    int unsigned  checked;
    int unsigned  n_push;
    int unsigned  n_pop;
    int unsigned  n_full;
    int unsigned  n_empty;
    int unsigned  peak;

    function new();
      held = 0;
      mismatches = 0;
      checked = 0;
      n_push = 0;
      n_pop = 0;
      n_full = 0;
      n_empty = 0;
      peak = 0;
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      logic [31:0] tk;
      logic [15:0] tp;
      tk = key_mem[a];
      tp = pay_mem[a];
      key_mem[a] = key_mem[b];
      pay_mem[a] = pay_mem[b];
      key_mem[b] = tk;
      pay_mem[b] = tp;
    endfunction

    // Applies one accepted operation and queues the result it must produce.
    function void note_operation(logic kind, logic [15:0] pay, logic [31:0] key);
      heap_result_t r;
      int unsigned  pos;
      int unsigned  parent;
      int unsigned  lc;
      int unsigned  rc;
      int unsigned  best;
      bit           settled;
      r.status  = bmhq_pkg::STATUS_OK;
      r.payload = '0;
      r.key     = '0;
      if (kind == bmhq_pkg::KIND_PUSH) begin
        n_push++;
        if (held >= DEPTH) begin
          r.status = bmhq_pkg::STATUS_FULL;
          n_full++;
        end else begin
          // Sift up while the parent key is strictly greater.
          pos = held;
          key_mem[pos] = key;
          pay_mem[pos] = pay;
          while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (key_mem[parent] > key_mem[pos]) begin
              swap_slots(parent, pos);
              pos = parent;
            end else begin
              break;
            end
          end
          held++;
          if (held > peak) peak = held;
        end
      end else begin
        n_pop++;
        if (held == 0) begin
          r.status = bmhq_pkg::STATUS_EMPTY;
          n_empty++;
        end else begin
          r.key     = key_mem[0];
          r.payload = pay_mem[0];
          held--;
          key_mem[0] = key_mem[held];
          pay_mem[0] = pay_mem[held];
          // Sift down; the left child wins ties and only a strictly
          // smaller child causes a swap.
          pos = 0;
          settled = 1'b0;
          while (!settled) begin
            best = pos;
            lc = 2 * pos + 1;
            rc = 2 * pos + 2;
            if (lc < held && key_mem[lc] < key_mem[best]) best = lc;
            if (rc < held && key_mem[rc] < key_mem[best]) best = rc;
            if (best == pos) begin
              settled = 1'b1;
            end else begin
              swap_slots(best, pos);
              pos = best;
            end
          end
        end
      end
      r.occupancy = held[10:0];
      awaited_results.push_back(r);
    endfunction

    // Compares one accepted result beat with the oldest expectation.
    function void check_beat(logic [1:0] status, logic [15:0] pay, logic [31:0] key,
                             logic [10:0] occ);
      heap_result_t e;
      checked++;
      if (awaited_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result beat status=%0d key=%h payload=%h occ=%0d",
                   status, key, pay, occ);
      end else begin
        e = awaited_results.pop_front();
        if (status !== e.status || pay !== e.payload || key !== e.key ||
            occ !== e.occupancy) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result %0d expected status=%0d key=%h payload=%h occ=%0d,",
                     checked, e.status, e.key, e.payload, e.occupancy);
            $display("       got status=%0d key=%h payload=%h occ=%0d",
                     status, key, pay, occ);
          end
        end
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [47:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  min_heap_predictor heap_model = new();
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned cycle_count = 0;

  binary_min_heap_queue i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always #5 clk_i = ~clk_i;

  // Offers one beat, after a random gap while idle_on, and records it once taken.
  task automatic send_op(input logic kind, input logic [15:0] pay, input logic [31:0] key);
    while (idle_on && $urandom_range(0, 99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {key, pay};
    do @(posedge clk_i); while (!s_axis_tready);
    heap_model.note_operation(kind, pay, key);
  endtask

  // Keys cluster on a few small values now and then so that ties occur.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 5))
      0, 1:    return 32'($urandom_range(0, 15));
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_mix(input int unsigned count, input int unsigned push_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < push_pct)
        send_op(bmhq_pkg::KIND_PUSH, 16'($urandom), pick_key());
      else
        send_op(bmhq_pkg::KIND_POP, 16'($urandom), $urandom);
    end
  endtask

  // Stops offering beats and waits until every owed result has arrived.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (heap_model.pending() != 0) @(posedge clk_i);
  endtask

  // Result side: random or steady ready, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        heap_model.check_beat(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[47:16],
                              m_axis_tdata[58:48]);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 38) : 1'b1;
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("binary_min_heap_queue_test: done, errors");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pop, key and payload extremes, the only entry, equal keys.
    send_op(bmhq_pkg::KIND_POP, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0000, 32'h0000_0000);
    send_op(bmhq_pkg::KIND_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
    send_op(bmhq_pkg::KIND_POP, 16'h0000, 32'h0);
    send_op(bmhq_pkg::KIND_POP, 16'h0000, 32'h0);
    send_op(bmhq_pkg::KIND_POP, 16'h0000, 32'h0);
    send_op(bmhq_pkg::KIND_PUSH, 16'hAAAA, 32'h5555_5555);
    send_op(bmhq_pkg::KIND_PUSH, 16'h5555, 32'hAAAA_AAAA);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0001, 32'd5);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0002, 32'd5);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0003, 32'd5);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0004, 32'd3);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0005, 32'd5);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0006, 32'd7);
    send_op(bmhq_pkg::KIND_PUSH, 16'h0007, 32'd3);
    for (int unsigned n = 0; n < 10; n++)
      send_op(bmhq_pkg::KIND_POP, 16'($urandom), $urandom);

    // Random, with one long receiver hold-off while beats keep coming.
    hold_req = 1'b1;
    run_mix(200, 65);
    // Sender pauses until the block has delivered everything.
    drain_results();
    idle_on = 1'b0;
    run_mix(150, 50);
    idle_on = 1'b1;
    run_mix(300, 35);

    // Empty the heap and finish with a pop on the empty heap.
    while (heap_model.held > 0)
      run_mix(1, 10);
    send_op(bmhq_pkg::KIND_POP, 16'($urandom), $urandom);

    drain_results();
    repeat (30) @(posedge clk_i);

    $display("Covered %0d pushes (%0d rejected full) and %0d pops (%0d on empty),",
             heap_model.n_push, heap_model.n_full, heap_model.n_pop, heap_model.n_empty);
    $display("peak %0d entries; checked %0d result beats, %0d mismatches, %0d awaited.",
             heap_model.peak, heap_model.checked, heap_model.mismatches,
             heap_model.pending());
    if (heap_model.mismatches == 0 && heap_model.pending() == 0)
      $display("binary_min_heap_queue_test: done, clean");
    else
      $display("binary_min_heap_queue_test: done, errors");
    $finish;
  end

endmodule
